// File: rtl/msq_pkg.sv
`default_nettype none

package msq_pkg;

	localparam int unsigned CAL_W    = 8;
	localparam int unsigned CFG_IX_W = 3;
	localparam int unsigned CFG_D_W  = 16;

	// indicator handling starts once more than this many calibration ticks have passed
	localparam int unsigned SETTLE_TICKS = 4;

	typedef enum logic [CFG_IX_W-1:0] {
		REG_PREP_TICKS      = 3'd0,
		REG_MOIST_WAIT      = 3'd1,
		REG_DRY_WAIT        = 3'd2,
		REG_MOIST_ON        = 3'd3,
		REG_MOIST_OFF       = 3'd4,
		REG_DRY_ON          = 3'd5,
		REG_DRY_OFF         = 3'd6
	} reg_index_t;

	localparam logic [7:0]  RST_PREP_TICKS = 8'd4;
	localparam logic [15:0] RST_MOIST_WAIT = 16'd3600;
	localparam logic [15:0] RST_DRY_WAIT   = 16'd60;
	localparam logic [7:0]  RST_MOIST_ON   = 8'd4;
	localparam logic [7:0]  RST_MOIST_OFF  = 8'd36;
	localparam logic [7:0]  RST_DRY_ON     = 8'd1;
	localparam logic [7:0]  RST_DRY_OFF    = 8'd3;

	typedef enum logic [1:0] {
		PH_PREPARE    = 2'd0,
		PH_TEST       = 2'd1,
		PH_WAIT_MOIST = 2'd2,
		PH_WAIT_DRY   = 2'd3
	} probe_phase_t;

	typedef enum logic [2:0] {
		BL_MOIST_ON  = 3'd0,
		BL_MOIST_OFF = 3'd1,
		BL_DRY_ON    = 3'd2,
		BL_DRY_OFF   = 3'd3,
		BL_INACTIVE  = 3'd4
	} blink_phase_t;

	typedef struct packed {
		logic [7:0]  prep_ticks;
		logic [15:0] moist_wait_ticks;
		logic [15:0] dry_wait_ticks;
		logic [7:0]  moist_on_ticks;
		logic [7:0]  moist_off_ticks;
		logic [7:0]  dry_on_ticks;
		logic [7:0]  dry_off_ticks;
	} msq_cfg_t;

	typedef struct packed {
		logic indicator_on;
		logic sensor_power;
		logic comparator_enable;
	} msq_res_t;

endpackage

`default_nettype wire

// File: rtl/msq_regs.sv
`default_nettype none

module msq_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [msq_pkg::CFG_IX_W-1:0]  wr_index,
	input  wire logic [msq_pkg::CFG_D_W-1:0]   wr_data,
	output msq_pkg::msq_cfg_t                  cfg
);
	import msq_pkg::*;

	msq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prep_ticks       <= RST_PREP_TICKS;
			cfg_q.moist_wait_ticks <= RST_MOIST_WAIT;
			cfg_q.dry_wait_ticks   <= RST_DRY_WAIT;
			cfg_q.moist_on_ticks   <= RST_MOIST_ON;
			cfg_q.moist_off_ticks  <= RST_MOIST_OFF;
			cfg_q.dry_on_ticks     <= RST_DRY_ON;
			cfg_q.dry_off_ticks    <= RST_DRY_OFF;
		end else if (wr_en) begin
			// wide data is truncated to the register width, unknown index ignored
			unique case (wr_index)
				REG_PREP_TICKS: cfg_q.prep_ticks       <= wr_data[7:0];
				REG_MOIST_WAIT: cfg_q.moist_wait_ticks <= wr_data;
				REG_DRY_WAIT:   cfg_q.dry_wait_ticks   <= wr_data;
				REG_MOIST_ON:   cfg_q.moist_on_ticks   <= wr_data[7:0];
				REG_MOIST_OFF:  cfg_q.moist_off_ticks  <= wr_data[7:0];
				REG_DRY_ON:     cfg_q.dry_on_ticks     <= wr_data[7:0];
				REG_DRY_OFF:    cfg_q.dry_off_ticks    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/msq_core.sv
`default_nettype none

module msq_core #(
	parameter int unsigned CALIBRATION_TICKS = 240
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic               dry,
	input  wire msq_pkg::msq_cfg_t  cfg,
	output msq_pkg::msq_res_t       res_d
);
	import msq_pkg::*;

	localparam logic [CAL_W-1:0] CAL_INIT  = CAL_W'(CALIBRATION_TICKS);
	localparam logic [CAL_W-1:0] CAL_SETTLE = CAL_W'(CALIBRATION_TICKS - SETTLE_TICKS);

	logic [CAL_W-1:0] cal_q, cal_d;
	probe_phase_t     pph_q, pph_d;
	logic [15:0]      pwait_q, pwait_d;
	blink_phase_t     bph_q, bph_d;
	logic [7:0]       bwait_q, bwait_d;
	logic             ind_q, ind_d;
	logic             pwr_q, pwr_d;
	logic             cen_q, cen_d;

	always_comb begin
		cal_d   = cal_q;
		pph_d   = pph_q;
		pwait_d = pwait_q;
		bph_d   = bph_q;
		bwait_d = bwait_q;
		ind_d   = ind_q;
		pwr_d   = pwr_q;
		cen_d   = cen_q;

		// calibration holds both machines off
		if (cal_q != '0) begin
			if (cal_q < CAL_SETTLE) begin
				ind_d = dry ? ~ind_q : 1'b0;
			end
			cal_d   = cal_q - 1'b1;
			pwait_d = 16'd1;
			bwait_d = 8'd1;
		end

		if (pwait_d == '0) begin
			unique case (pph_q)
				PH_PREPARE: begin
					cen_d   = 1'b1;
					pwr_d   = 1'b1;
					pwait_d = {8'd0, cfg.prep_ticks};
					pph_d   = PH_TEST;
					bwait_d = '0;
				end
				PH_TEST: begin
					pph_d = dry ? PH_WAIT_DRY : PH_WAIT_MOIST;
					cen_d = 1'b0;
					pwr_d = 1'b0;
					bph_d = BL_INACTIVE;
				end
				PH_WAIT_MOIST: begin
					pwait_d = cfg.moist_wait_ticks;
					pph_d   = PH_PREPARE;
					bph_d   = BL_MOIST_ON;
				end
				default: begin
					pwait_d = cfg.dry_wait_ticks;
					pph_d   = PH_PREPARE;
					bph_d   = BL_DRY_ON;
				end
			endcase
		end

		if (bwait_d == '0) begin
			unique case (bph_d)
				BL_MOIST_ON: begin
					bwait_d = cfg.moist_on_ticks;
					ind_d   = 1'b1;
					bph_d   = BL_MOIST_OFF;
				end
				BL_MOIST_OFF: begin
					bwait_d = cfg.moist_off_ticks;
					ind_d   = 1'b0;
					bph_d   = BL_MOIST_ON;
				end
				BL_DRY_ON: begin
					bwait_d = cfg.dry_on_ticks;
					ind_d   = 1'b1;
					bph_d   = BL_DRY_OFF;
				end
				BL_DRY_OFF: begin
					bwait_d = cfg.dry_off_ticks;
					ind_d   = 1'b0;
					bph_d   = BL_DRY_ON;
				end
				default: begin
					ind_d = 1'b0;
				end
			endcase
		end

		if (pwait_d != '0) begin
			pwait_d = pwait_d - 1'b1;
		end
		if (bwait_d != '0) begin
			bwait_d = bwait_d - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q   <= CAL_INIT;
			pph_q   <= PH_PREPARE;
			pwait_q <= '0;
			bph_q   <= BL_MOIST_OFF;
			bwait_q <= '0;
			ind_q   <= 1'b0;
			pwr_q   <= 1'b0;
			cen_q   <= 1'b1;
		end else if (step) begin
			cal_q   <= cal_d;
			pph_q   <= pph_d;
			pwait_q <= pwait_d;
			bph_q   <= bph_d;
			bwait_q <= bwait_d;
			ind_q   <= ind_d;
			pwr_q   <= pwr_d;
			cen_q   <= cen_d;
		end
	end

	assign res_d.indicator_on      = ind_d;
	assign res_d.sensor_power      = pwr_d;
	assign res_d.comparator_enable = cen_d;

endmodule

`default_nettype wire

// File: rtl/moisture_probe_sequencer_unit.sv
// moisture probe sequencer: one timer tick in, one output level set out
//
// in channel: in_valid/in_ready with comparator_dry (1 = soil reads dry)
// out channel: out_valid/out_ready with indicator_on, sensor_power and
//   comparator_enable, the levels after the tick
// cfg channel: cfg_valid/cfg_ready (always ready), cfg_index selects one of
//   seven timing registers, cfg_data holds the value (low bits kept for
//   8-bit registers, index 7 ignored); write only while the block is idle
// latency: a request accepted at one edge shows its result at the next edge
// throughput: one tick per cycle; the state update is one pass of logic
//   between the state registers and the result register
// stall: a held result stays put while a new tick is still accepted in the
//   same cycle the old result leaves; with out_ready low the input blocks
// reset: timing registers take their defaults, calibration restarts with
//   CALIBRATION_TICKS ticks, no result is pending
`default_nettype none

module moisture_probe_sequencer_unit #(
	parameter int unsigned CALIBRATION_TICKS = 240
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// tick requests
	input  wire logic                          in_valid,
	output wire logic                          in_ready,
	input  wire logic                          comparator_dry,
	// result requests
	output wire logic                          out_valid,
	input  wire logic                          out_ready,
	output wire logic                          indicator_on,
	output wire logic                          sensor_power,
	output wire logic                          comparator_enable,
	// register writes
	input  wire logic                          cfg_valid,
	output wire logic                          cfg_ready,
	input  wire logic [msq_pkg::CFG_IX_W-1:0]  cfg_index,
	input  wire logic [msq_pkg::CFG_D_W-1:0]   cfg_data
);
	import msq_pkg::*;

	msq_cfg_t cfg;
	msq_res_t res_d;
	msq_res_t res_q;
	logic     out_valid_q;
	logic     step;

	// a tick goes in whenever the result slot is empty or drains this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	msq_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	msq_core #(
		.CALIBRATION_TICKS (CALIBRATION_TICKS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.dry    (comparator_dry),
		.cfg    (cfg),
		.res_d  (res_d)
	);

	// result register, valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload, loaded with each accepted tick
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign indicator_on      = res_q.indicator_on;
	assign sensor_power      = res_q.sensor_power;
	assign comparator_enable = res_q.comparator_enable;

endmodule

`default_nettype wire

// File: rtl/msq_checker.sv
`default_nettype none

module msq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic indicator_on,
	input wire logic sensor_power,
	input wire logic comparator_enable
);

	// a held result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps its levels
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(indicator_on) && $stable(sensor_power)
			&& $stable(comparator_enable))
		else $error("result changed while stalled");

	// empty result slot never blocks a tick
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with no pending result");

	// every accepted tick yields a result on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick produced no result");

	// with output stalled and a result held, no new tick is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("tick accepted over a held result");

endmodule

bind moisture_probe_sequencer_unit msq_checker u_msq_checker (.*);

`default_nettype wire
